/* rtl/ksc_pkg.sv */
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared constants, operation codes and command types for the keyword
// substitution cipher.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int LETTERS     = 26;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_Z     = 8'd90;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // Operation codes on in_operation
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_KEY     = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_ENCRYPT = 3'd3;
  localparam logic [2:0] OP_DECRYPT = 3'd4;

  typedef logic [4:0] letter_t;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_KEY     = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_ENCRYPT = 3'd3,
    CMD_DECRYPT = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      is_letter;
    letter_t   letter;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/ksc_front.sv */
// ----------------------------------------------------------------------------
// ksc_front
// Accepts requests, decodes the operation and the letter, and pushes every
// command except unused codes and non-letter key symbols into the command queue.
// ----------------------------------------------------------------------------
module ksc_front (
  input  logic           start,
  input  logic [2:0]     in_operation,
  input  logic [7:0]     in_symbol,
  input  ksc_pkg::q_stat_t q_stat,
  output logic           busy,
  output logic           push,
  output ksc_pkg::cmd_t  push_data
);
  import ksc_pkg::*;

  logic    accept;
  logic    is_letter;
  logic    useful;
  logic [7:0] offset;

  assign busy      = q_stat.full;
  assign accept    = start && !q_stat.full;
  assign is_letter = (in_symbol >= CHAR_A) && (in_symbol <= CHAR_Z);
  assign offset    = in_symbol - CHAR_A;

  always_comb begin
    push_data.is_letter = is_letter;
    push_data.letter    = offset[4:0];
    push_data.kind      = CMD_START;
    useful              = 1'b1;
    case (in_operation)
      OP_START:   push_data.kind = CMD_START;
      OP_KEY: begin
        push_data.kind = CMD_KEY;
        useful         = is_letter;   // non-letters in the key are dropped
      end
      OP_FINISH:  push_data.kind = CMD_FINISH;
      OP_ENCRYPT: push_data.kind = CMD_ENCRYPT;
      OP_DECRYPT: push_data.kind = CMD_DECRYPT;
      default:    useful = 1'b0;      // unused codes do nothing
    endcase
  end

  assign push = accept && useful;

endmodule

/* rtl/ksc_queue.sv */
// ----------------------------------------------------------------------------
// ksc_queue
// Small first-in first-out command queue between front and back.
// ----------------------------------------------------------------------------
module ksc_queue #(
  parameter int DEPTH = ksc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ksc_pkg::cmd_t    push_data,
  input  logic             pop,
  output ksc_pkg::cmd_t    pop_data,
  output ksc_pkg::q_stat_t q_stat
);
  import ksc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/ksc_back.sv */
// ----------------------------------------------------------------------------
// ksc_back
// Executes queued commands: key building, alphabet completion (one letter
// a cycle, Z down to A) and table lookups with a registered result.
// ----------------------------------------------------------------------------
module ksc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ksc_pkg::q_stat_t q_stat,
  input  ksc_pkg::cmd_t    cmd,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_symbol_out
);
  import ksc_pkg::*;

  typedef enum logic [1:0] {
    ST_EXEC = 2'b01,
    ST_FILL = 2'b10
  } back_state_t;

  localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);
  localparam letter_t FILL_END    = letter_t'(LETTERS);

  back_state_t          state_r, state_nxt;
  letter_t              fwd_r [LETTERS];
  letter_t              inv_r [LETTERS];
  logic [LETTERS-1:0]   used_r, used_nxt;
  letter_t              fill_r, fill_nxt;
  letter_t              walk_r, walk_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_sym_r, out_sym_nxt;

  logic    place_req;
  letter_t place_letter;
  logic    place_ok;
  letter_t lookup;

  assign pop = (state_r == ST_EXEC) && !q_stat.empty;

  // A letter is placed only if the alphabet has room and it is not yet used
  assign place_ok = place_req && (fill_r < FILL_END) && !used_r[place_letter];

  assign lookup = (cmd.kind == CMD_ENCRYPT) ? fwd_r[cmd.letter] : inv_r[cmd.letter];

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    walk_nxt      = walk_r;
    out_valid_nxt = 1'b0;
    out_sym_nxt   = out_sym_r;
    place_req     = 1'b0;
    place_letter  = cmd.letter;

    case (state_r)
      ST_EXEC: begin
        if (pop) begin
          case (cmd.kind)
            CMD_START: begin
              used_nxt = '0;
              fill_nxt = '0;
            end
            CMD_KEY: begin
              place_req = cmd.is_letter;
            end
            CMD_FINISH: begin
              state_nxt = ST_FILL;
              walk_nxt  = LAST_LETTER;
            end
            CMD_ENCRYPT, CMD_DECRYPT: begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = cmd.is_letter ? (CHAR_A + {3'b000, lookup}) : CHAR_SPACE;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_req    = 1'b1;
        place_letter = walk_r;
        if (walk_r == '0) begin
          state_nxt = ST_EXEC;
        end else begin
          walk_nxt = walk_r - 1'b1;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase

    if (place_ok) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      used_r      <= '0;
      fill_r      <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LETTERS; i++) begin
        fwd_r[i] <= letter_t'(LETTERS - 1 - i);
        inv_r[i] <= letter_t'(LETTERS - 1 - i);
      end
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (place_ok) begin
        fwd_r[fill_r]       <= place_letter;
        inv_r[place_letter] <= fill_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r <= out_sym_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;

endmodule

/* rtl/keyword_substitution_cipher_top.sv */
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_top
// Keyword substitution cipher: builds a cipher alphabet from a keyword and
// encrypts or decrypts bytes through it.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                               Transfer
//  --------  ----------------------------------  ------------------------------
//  request   start, busy, in_operation,          taken when start && !busy
//            in_symbol
//  result    out_valid, out_symbol_out           one-cycle strobe, no back-off
//
//  Start, key letter, encrypt and decrypt are each executed as one back-end
//  command; a result passes through the command queue and the result register.
//  Finish key starts the alphabet completion: it walks the 26 letters one per
//  cycle, Z down to A, through the single table write port.
//  busy rises only when the four-entry command queue is full; the back end
//  drains it independently, so text flows at one byte per cycle outside a finish.
//  Reset (synchronous, rst_n low) empties the queue, loads both tables with
//  the reversed alphabet and clears the used-letter mask and fill position.
//  The receiver cannot stall: every result appears exactly once.
//
module keyword_substitution_cipher_top #(
  parameter int QUEUE_DEPTH = ksc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  output logic [7:0] out_symbol_out
);
  import ksc_pkg::*;

  // front -> queue
  logic    push;
  cmd_t    push_data;
  // queue -> back
  logic    pop;
  cmd_t    pop_data;
  q_stat_t q_stat;

  // Front end: decodes the request, drops unused codes and non-letter key symbols
  ksc_front u_front (
    .start        (start),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .q_stat       (q_stat),
    .busy         (busy),
    .push         (push),
    .push_data    (push_data)
  );

  // Decoupling queue, so that a long finish does not block new requests
  ksc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back end: owns the tables and the registered result
  ksc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .cmd            (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_symbol_out (out_symbol_out)
  );

endmodule

/* rtl/ksc_checker.sv */
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks for the keyword substitution cipher, bound to the top.
// ----------------------------------------------------------------------------
module ksc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_operation,
  input logic [7:0] in_symbol,
  input logic       out_valid,
  input logic [7:0] out_symbol_out
);
  import ksc_pkg::*;

  // Reset leaves nothing pending and nothing to show
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("output or busy active after reset");

  // Results are always a capital letter or a space
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_symbol_out == CHAR_SPACE) ||
                   ((out_symbol_out >= CHAR_A) && (out_symbol_out <= CHAR_Z))))
    else $error("result byte outside A-Z and space");

  // The queue can only fill on a taken request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a request being taken");

  // A taken request carries a fully known operation and symbol
  a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown({in_operation, in_symbol}))
    else $error("request taken with unknown operation or symbol");

endmodule

bind keyword_substitution_cipher_top ksc_checker u_ksc_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyword substitution cipher. A short walk
// through hand-picked requests (reset alphabet, byte extremes, unused codes,
// repeated and stray key letters, double finish) is followed by random key
// sessions, each a keyword and then a run of text. Every taken request also
// updates a local cipher-alphabet predictor. Each strobed output byte is
// checked in order against the predicted byte.
// ----------------------------------------------------------------------------
module testbench;
  import ksc_pkg::*;

  // Operation codes the block must ignore
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  localparam int RANDOM_REQUESTS = 1150;
  localparam int DIRECTED_ROWS   = 25;
  // Four queued finish requests, each a full alphabet completion, plus margin
  localparam int DRAIN_CYCLES    = 160;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] sym;
    bit         has_fixed;   // expected byte known without the predictor
    logic [7:0] fixed_out;
  } req_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_operation;
  logic [7:0] in_symbol;
  logic       out_valid;
  logic [7:0] out_symbol_out;

  // Predicted cipher state
  logic [4:0]  plain_to_cipher [LETTERS];
  logic [4:0]  cipher_to_plain [LETTERS];
  logic [25:0] letters_taken;
  int          next_slot;

  logic [7:0] cipher_bytes_due [$];
  logic [7:0] byte_due;
  int         mismatches;
  int         sent_count;
  int         cycle_count;
  bit         no_idle;

  // Directed walk: reset alphabet maps A<->Z, so the first rows are known
  req_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_ENCRYPT, "A",   1'b1, "Z"},
    '{OP_ENCRYPT, "Z",   1'b1, "A"},
    '{OP_DECRYPT, "A",   1'b1, "Z"},
    '{OP_DECRYPT, "Z",   1'b1, "A"},
    '{OP_ENCRYPT, 8'h00, 1'b1, CHAR_SPACE},
    '{OP_ENCRYPT, 8'hFF, 1'b1, CHAR_SPACE},
    '{OP_DECRYPT, "@",   1'b1, CHAR_SPACE},
    '{OP_DECRYPT, "[",   1'b1, CHAR_SPACE},
    '{OP_ENCRYPT, "a",   1'b1, CHAR_SPACE},
    '{OP_UNUSED_LO, "A", 1'b0, 8'h00},
    '{OP_UNUSED_HI, 8'hFF, 1'b0, 8'h00},
    '{OP_START,   8'h00, 1'b0, 8'h00},
    '{OP_KEY,     "K",   1'b0, 8'h00},
    '{OP_KEY,     "E",   1'b0, 8'h00},
    '{OP_KEY,     "K",   1'b0, 8'h00},  // repeat, skipped
    '{OP_KEY,     "1",   1'b0, 8'h00},  // not a letter, ignored
    '{OP_KEY,     8'hFF, 1'b0, 8'h00},
    '{OP_ENCRYPT, "A",   1'b0, 8'h00},  // half-built tables
    '{OP_DECRYPT, "E",   1'b0, 8'h00},
    '{OP_FINISH,  8'h00, 1'b0, 8'h00},
    '{OP_FINISH,  8'h00, 1'b0, 8'h00},  // second finish is a no-op
    '{OP_KEY,     "Q",   1'b0, 8'h00},  // after finish, ignored
    '{OP_ENCRYPT, "Q",   1'b0, 8'h00},
    '{OP_DECRYPT, "Z",   1'b0, 8'h00},
    '{OP_UNUSED_MID, "Z", 1'b0, 8'h00}
  };

  keyword_substitution_cipher_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_symbol_out (out_symbol_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit is_upper(input logic [7:0] sym);
    return (sym >= CHAR_A) && (sym <= CHAR_Z);
  endfunction

  // Puts a letter at the next free alphabet slot unless used or full
  function automatic void place_letter(input int letter);
    if (next_slot >= LETTERS || letters_taken[letter])
      return;
    plain_to_cipher[next_slot] = letter_t'(letter);
    cipher_to_plain[letter]    = letter_t'(next_slot);
    letters_taken[letter]      = 1'b1;
    next_slot++;
  endfunction

  function automatic void cipher_state_reset();
    for (int i = 0; i < LETTERS; i++) begin
      plain_to_cipher[i] = letter_t'(LETTERS - 1 - i);
      cipher_to_plain[i] = letter_t'(LETTERS - 1 - i);
    end
    letters_taken = '0;
    next_slot     = 0;
  endfunction

  function automatic void substitute_predict(input logic [2:0] op, input logic [7:0] sym,
                                             output bit has_out, output logic [7:0] sym_out);
    int idx;
    idx     = int'(sym) - int'(CHAR_A);
    has_out = 1'b0;
    sym_out = CHAR_SPACE;
    case (op)
      OP_START: begin
        letters_taken = '0;
        next_slot     = 0;
      end
      OP_KEY: begin
        if (is_upper(sym))
          place_letter(idx);
      end
      OP_FINISH: begin
        // Unused letters go in Z down to A
        for (int k = LETTERS - 1; k >= 0; k--)
          place_letter(k);
      end
      OP_ENCRYPT: begin
        has_out = 1'b1;
        if (is_upper(sym))
          sym_out = CHAR_A + {3'b000, plain_to_cipher[idx]};
      end
      OP_DECRYPT: begin
        has_out = 1'b1;
        if (is_upper(sym))
          sym_out = CHAR_A + {3'b000, cipher_to_plain[idx]};
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side: driven on the falling edge, taken on the rising edge
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] op, input logic [7:0] sym,
                              input bit has_fixed, input logic [7:0] fixed_out);
    bit         has_out;
    logic [7:0] pred_out;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_symbol    <= sym;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    // Request taken at this edge
    substitute_predict(op, sym, has_out, pred_out);
    if (has_out)
      cipher_bytes_due.push_back(has_fixed ? fixed_out : pred_out);
    sent_count++;
  endtask

  task automatic send_random(input logic [2:0] op, input logic [7:0] sym);
    send_request(op, sym, 1'b0, 8'h00);
    idle_gap();
  endtask

  // Mostly back to back, sometimes a short idle gap, now and then a long gap;
  // the idle bus carries junk so that only start qualifies a request
  task automatic idle_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60)
      gap = 0;
    else if (pick < 94)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 40);
    repeat (gap) begin
      @(negedge clk);
      start        <= 1'b0;
      in_operation <= 3'($urandom);
      in_symbol    <= 8'($urandom);
    end
  endtask

  function automatic logic [7:0] key_byte();
    if ($urandom_range(0, 99) < 85)
      return CHAR_A + 8'($urandom_range(0, LETTERS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 99) < 80)
      return CHAR_A + 8'($urandom_range(0, LETTERS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // One keyword followed by a run of text, with the odd broken sequence
  task automatic key_session();
    logic [4:0] perm [LETTERS];
    logic [4:0] swap;
    int         j;
    int         pick;
    no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0)
      send_random(OP_START, 8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      // Whole alphabet as keyword, then letters into a full alphabet
      for (int i = 0; i < LETTERS; i++)
        perm[i] = letter_t'(i);
      for (int i = LETTERS - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        swap    = perm[i];
        perm[i] = perm[j];
        perm[j] = swap;
      end
      for (int i = 0; i < LETTERS; i++)
        send_random(OP_KEY, CHAR_A + {3'b000, perm[i]});
      repeat ($urandom_range(1, 3))
        send_random(OP_KEY, key_byte());
    end else begin
      repeat ($urandom_range(0, 12))
        send_random(OP_KEY, key_byte());
    end
    pick = $urandom_range(0, 99);
    if (pick < 90)
      send_random(OP_FINISH, 8'($urandom));
    if (pick < 6)
      send_random(OP_FINISH, 8'($urandom));
    repeat ($urandom_range(4, 30)) begin
      pick = $urandom_range(0, 99);
      if (pick < 47)
        send_random(OP_ENCRYPT, text_byte());
      else if (pick < 94)
        send_random(OP_DECRYPT, text_byte());
      else if (pick < 97)
        send_random(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom));
      else
        send_random(OP_KEY, key_byte());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: strobed bytes checked in order of request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (cipher_bytes_due.size() == 0) begin
        $display("%0t: unexpected symbol_out: expected none, actual %0d",
                 $time, out_symbol_out);
        mismatches++;
      end else begin
        byte_due = cipher_bytes_due.pop_front();
        if (out_symbol_out !== byte_due) begin
          $display("%0t: symbol_out mismatch: expected %0d, actual %0d",
                   $time, byte_due, out_symbol_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d bytes outstanding", $time,
               cipher_bytes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit paused;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_START;
    in_symbol    = 8'h00;
    mismatches   = 0;
    sent_count   = 0;
    cycle_count  = 0;
    no_idle      = 1'b0;
    paused       = 1'b0;
    cipher_state_reset();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].sym,
                   directed_rows[i].has_fixed, directed_rows[i].fixed_out);
      idle_gap();
    end

    while (sent_count < DIRECTED_ROWS + RANDOM_REQUESTS) begin
      key_session();
      // Hold off once mid-run until every pending byte is back
      if (!paused && sent_count > RANDOM_REQUESTS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        start <= 1'b0;
        while (cipher_bytes_due.size() != 0)
          @(posedge clk);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (cipher_bytes_due.size() != 0)
      @(posedge clk);
    // Queued finish requests produce nothing; let any stray strobe show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (cipher_bytes_due.size() != 0) begin
      $display("%0t: %0d bytes never returned: expected %0d, actual none", $time,
               cipher_bytes_due.size(), cipher_bytes_due[0]);
      mismatches++;
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* keyword_substitution_cipher_top.f */
rtl/ksc_pkg.sv
rtl/ksc_front.sv
rtl/ksc_queue.sv
rtl/ksc_back.sv
rtl/keyword_substitution_cipher_top.sv
rtl/ksc_checker.sv
verif/testbench.sv
